/* rtl/core/rci_pkg.sv */
// shared types, constants and conversion functions for the ray/capsule test
// no dependencies; every other file in rtl/core imports this package
package rci_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // port widths
    localparam int IN_W   = 32;
    localparam int LEN_W  = 31;
    localparam int HD_W   = 31;
    // ray fraction and the fixed scale used for the closest-point offsets
    localparam int QB     = 16;

    localparam int CW     = COORD_WIDTH;
    localparam int RAD_W  = CW - 1;
    localparam int D1_W   = CW + 1;
    localparam int PRD_W  = 2 * D1_W;
    localparam int WIDE_W = 2 * CW + 4;
    localparam int PM_W   = CW + RAD_W;
    localparam int UW     = D1_W + QB + 2;
    localparam int MG_W   = RAD_W + QB;
    localparam int MG_LO  = (MG_W + 1) / 2;
    localparam int MG_HI  = MG_W - MG_LO;
    localparam int SS_W   = 2 * MG_W + 2;

    localparam longint CMAX   = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN   = -CMAX - 1;
    // 1e-8 on squared lengths, in LSBs of the squared format
    localparam longint EPS_SQ = (longint'(1) << (2 * FRAC_BITS)) / 100000000;
    localparam int ONE_FRAC   = 1 << QB;

    typedef logic signed [CW-1:0]    coord_t;
    typedef logic signed [D1_W-1:0]  diff_t;
    typedef logic [CW:0]             glen_t;
    typedef logic [RAD_W-1:0]        len_t;
    typedef logic [2*RAD_W-1:0]      rr_t;
    typedef logic signed [PRD_W-1:0] prd_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [UW-1:0]    uw_t;
    typedef logic [QB:0]             frac_t;

    // which offset the axis point takes along y
    typedef enum logic [1:0] {
        Y_R1   = 2'd0,
        Y_RQ   = 2'd1,
        Y_ZERO = 2'd2
    } ysel_t;

    // context carried alongside the dividers
    typedef struct packed {
        diff_t d1x;
        diff_t d1y;
        diff_t d1z;
        diff_t r0;
        diff_t r1;
        diff_t r2;
        diff_t rq;
        glen_t g;
        wide_t a;
        wide_t negc;
        wide_t numc;
        len_t  m;
        len_t  rad;
        rr_t   rr;
        logic  adeg;
        logic  gdeg;
        logic  usediv;
        ysel_t ysel;
        frac_t sqfix;
    } ctx_t;

    function automatic coord_t coord_in(input logic [IN_W-1:0] v);
        logic signed [63:0] x;
        x = 64'(signed'(v));
        if (x > CMAX) x = CMAX;
        else if (x < CMIN) x = CMIN;
        return coord_t'(x);
    endfunction

    function automatic coord_t sat_coord(input logic signed [CW+1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > CMAX) x = CMAX;
        else if (x < CMIN) x = CMIN;
        return coord_t'(x);
    endfunction

    function automatic len_t len_in(input logic [LEN_W-1:0] v);
        logic [63:0] x;
        x = 64'(v);
        if (x > 64'(CMAX)) x = 64'(CMAX);
        return len_t'(x);
    endfunction

endpackage

/* rtl/core/ray_capsule_intersection_top.sv */
// ray versus upright capsule test, fully pipelined
// the done strobe is high in the same cycle as the result that it marks on
// hit, hit_distance and ray_fraction
// throughput: one item per cycle, busy stays low; the two 17-stage dividers
// make up most of the pipeline
// reset: rst_n clears all valid bits, no result is pending after reset
// the receiver cannot stall; every item gives exactly one result
module ray_capsule_intersection_top
    import rci_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] ray_origin_x,
    input  logic signed [IN_W-1:0] ray_origin_y,
    input  logic signed [IN_W-1:0] ray_origin_z,
    input  logic signed [IN_W-1:0] ray_dir_x,
    input  logic signed [IN_W-1:0] ray_dir_y,
    input  logic signed [IN_W-1:0] ray_dir_z,
    input  logic [LEN_W-1:0]       max_distance,
    input  logic signed [IN_W-1:0] capsule_center_x,
    input  logic signed [IN_W-1:0] capsule_center_y,
    input  logic signed [IN_W-1:0] capsule_center_z,
    input  logic [LEN_W-1:0]       capsule_radius,
    input  logic [LEN_W-1:0]       capsule_height_scale,
    output logic                   done,
    output logic                   hit,
    output logic [HD_W-1:0]        hit_distance,
    output logic [QB:0]            ray_fraction
);

    logic  fr_v, da_v, se_v, db_v;
    wide_t fr_num, fr_den, se_num, se_den;
    ctx_t  fr_ctx, da_ctx, se_ctx, db_ctx;
    frac_t da_q, db_q;

    assign busy = 1'b0;

    // conversion, ray end, dot products
    rci_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .ray_origin_x         (ray_origin_x),
        .ray_origin_y         (ray_origin_y),
        .ray_origin_z         (ray_origin_z),
        .ray_dir_x            (ray_dir_x),
        .ray_dir_y            (ray_dir_y),
        .ray_dir_z            (ray_dir_z),
        .max_distance         (max_distance),
        .capsule_center_x     (capsule_center_x),
        .capsule_center_y     (capsule_center_y),
        .capsule_center_z     (capsule_center_z),
        .capsule_radius       (capsule_radius),
        .capsule_height_scale (capsule_height_scale),
        .v_out                (fr_v),
        .num_out              (fr_num),
        .den_out              (fr_den),
        .ctx_out              (fr_ctx)
    );

    // horizontal fraction
    rci_divider u_div_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (fr_v),
        .num_in   (fr_num),
        .den_in   (fr_den),
        .ctx_in   (fr_ctx),
        .v_out    (da_v),
        .quot_out (da_q),
        .ctx_out  (da_ctx)
    );

    // axis clamp check
    rci_select u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .v_in    (da_v),
        .sq0_in  (da_q),
        .ctx_in  (da_ctx),
        .v_out   (se_v),
        .num_out (se_num),
        .den_out (se_den),
        .ctx_out (se_ctx)
    );

    // fraction against the full ray length
    rci_divider u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (se_v),
        .num_in   (se_num),
        .den_in   (se_den),
        .ctx_in   (se_ctx),
        .v_out    (db_v),
        .quot_out (db_q),
        .ctx_out  (db_ctx)
    );

    // distance test and result registers
    rci_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .v_in         (db_v),
        .quot_in      (db_q),
        .ctx_in       (db_ctx),
        .done         (done),
        .hit          (hit),
        .hit_distance (hit_distance),
        .ray_fraction (ray_fraction)
    );

endmodule

/* rtl/core/rci_front.sv */
// front end: input conversion, ray end, capsule axis, dot products
// six register stages; depends on rci_pkg
module rci_front
    import rci_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [IN_W-1:0] ray_origin_x,
    input  logic signed [IN_W-1:0] ray_origin_y,
    input  logic signed [IN_W-1:0] ray_origin_z,
    input  logic signed [IN_W-1:0] ray_dir_x,
    input  logic signed [IN_W-1:0] ray_dir_y,
    input  logic signed [IN_W-1:0] ray_dir_z,
    input  logic [LEN_W-1:0]       max_distance,
    input  logic signed [IN_W-1:0] capsule_center_x,
    input  logic signed [IN_W-1:0] capsule_center_y,
    input  logic signed [IN_W-1:0] capsule_center_z,
    input  logic [LEN_W-1:0]       capsule_radius,
    input  logic [LEN_W-1:0]       capsule_height_scale,
    output logic                   v_out,
    output wide_t                  num_out,
    output wide_t                  den_out,
    output ctx_t                   ctx_out
);

    logic [5:0] v_reg;

    // stage 1
    coord_t           o1_reg [3];
    coord_t           cc1_reg [3];
    logic [PM_W-1:0]  pm1_reg [3];
    logic             dn1_reg [3];
    len_t             h1_reg, rad1_reg, m1_reg;
    coord_t           o_next [3];
    coord_t           dv_next [3];
    coord_t           cc_next [3];
    logic [CW-1:0]    dmag_next [3];
    len_t             rad_next, hs_next, m_next;

    // stage 2
    coord_t           o2_reg [3];
    coord_t           e2_reg [3];
    coord_t           ccx2_reg, ccz2_reg, p2y_reg, q2y_reg;
    len_t             rad2_reg, m2_reg;
    rr_t              rr2_reg;
    logic [PM_W-FRAC_BITS-1:0] lo_next [3];
    logic [CW:0]               stm_next [3];
    logic signed [CW+1:0]      st_next [3];

    // stage 3
    diff_t            d13_reg [3];
    diff_t            r3_reg [3];
    diff_t            rq3_reg;
    glen_t            g3_reg;
    len_t             rad3_reg, m3_reg;
    rr_t              rr3_reg;

    // stage 4
    prd_t             sq4_reg [3];
    prd_t             dr4_reg [3];
    prd_t             yg4_reg;
    logic [2*CW+1:0]  gg4_reg;
    diff_t            d14_reg [3];
    diff_t            r4_reg [3];
    diff_t            rq4_reg;
    glen_t            g4_reg;
    len_t             rad4_reg, m4_reg;
    rr_t              rr4_reg;

    // stage 5
    wide_t            a5_reg, c5_reg, hz5_reg, nh5_reg;
    prd_t             yg5_reg;
    logic             gdeg5_reg;
    diff_t            d15_reg [3];
    diff_t            r5_reg [3];
    diff_t            rq5_reg;
    glen_t            g5_reg;
    len_t             rad5_reg, m5_reg;
    rr_t              rr5_reg;

    // stage 6
    wide_t            num6_reg, den6_reg;
    ctx_t             ctx6_reg;
    ctx_t             ctx_next;

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], start};
        end
    end

    // input conversion and direction times length
    always_comb
    begin
        o_next[0]  = coord_in(ray_origin_x);
        o_next[1]  = coord_in(ray_origin_y);
        o_next[2]  = coord_in(ray_origin_z);
        dv_next[0] = coord_in(ray_dir_x);
        dv_next[1] = coord_in(ray_dir_y);
        dv_next[2] = coord_in(ray_dir_z);
        cc_next[0] = coord_in(capsule_center_x);
        cc_next[1] = coord_in(capsule_center_y);
        cc_next[2] = coord_in(capsule_center_z);
        rad_next   = len_in(capsule_radius);
        hs_next    = len_in(capsule_height_scale);
        m_next     = len_in(max_distance);
        for (int i = 0; i < 3; i++)
        begin
            dmag_next[i] = dv_next[i][CW-1] ? CW'(-dv_next[i]) : CW'(dv_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            o1_reg[i]  <= o_next[i];
            cc1_reg[i] <= cc_next[i];
            dn1_reg[i] <= dv_next[i][CW-1];
            pm1_reg[i] <= PM_W'(dmag_next[i]) * PM_W'(m_next);
        end
        h1_reg   <= (hs_next > rad_next) ? len_t'(hs_next - rad_next) : '0;
        rad1_reg <= rad_next;
        m1_reg   <= m_next;
    end

    // ray end with clipped step, axis endpoints
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_next[i]  = (PM_W-FRAC_BITS)'(pm1_reg[i] >> FRAC_BITS);
            stm_next[i] = (lo_next[i] > (PM_W-FRAC_BITS)'(longint'(1) << CW))
                          ? (CW+1)'(longint'(1) << CW) : (CW+1)'(lo_next[i]);
            st_next[i]  = signed'({1'b0, stm_next[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            o2_reg[i] <= o1_reg[i];
            e2_reg[i] <= sat_coord((CW+2)'(o1_reg[i])
                                   + (dn1_reg[i] ? -st_next[i] : st_next[i]));
        end
        ccx2_reg <= cc1_reg[0];
        ccz2_reg <= cc1_reg[2];
        p2y_reg  <= sat_coord((CW+2)'(cc1_reg[1]) - signed'((CW+2)'(h1_reg)));
        q2y_reg  <= sat_coord((CW+2)'(cc1_reg[1]) + signed'((CW+2)'(h1_reg)));
        rad2_reg <= rad1_reg;
        m2_reg   <= m1_reg;
        rr2_reg  <= rr_t'(rad1_reg) * rr_t'(rad1_reg);
    end

    // segment vectors and origin offsets
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d13_reg[i] <= diff_t'(e2_reg[i]) - diff_t'(o2_reg[i]);
        end
        r3_reg[0] <= diff_t'(o2_reg[0]) - diff_t'(ccx2_reg);
        r3_reg[1] <= diff_t'(o2_reg[1]) - diff_t'(p2y_reg);
        r3_reg[2] <= diff_t'(o2_reg[2]) - diff_t'(ccz2_reg);
        rq3_reg   <= diff_t'(o2_reg[1]) - diff_t'(q2y_reg);
        g3_reg    <= glen_t'(diff_t'(q2y_reg) - diff_t'(p2y_reg));
        rad3_reg  <= rad2_reg;
        m3_reg    <= m2_reg;
        rr3_reg   <= rr2_reg;
    end

    // products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq4_reg[i] <= prd_t'(d13_reg[i]) * prd_t'(d13_reg[i]);
            dr4_reg[i] <= prd_t'(d13_reg[i]) * prd_t'(r3_reg[i]);
            d14_reg[i] <= d13_reg[i];
            r4_reg[i]  <= r3_reg[i];
        end
        yg4_reg  <= prd_t'(d13_reg[1]) * prd_t'(signed'({1'b0, g3_reg}));
        gg4_reg  <= (2*CW+2)'(g3_reg) * (2*CW+2)'(g3_reg);
        rq4_reg  <= rq3_reg;
        g4_reg   <= g3_reg;
        rad4_reg <= rad3_reg;
        m4_reg   <= m3_reg;
        rr4_reg  <= rr3_reg;
    end

    // dot product sums
    always_ff @(posedge clk)
    begin
        a5_reg    <= wide_t'(sq4_reg[0]) + wide_t'(sq4_reg[1]) + wide_t'(sq4_reg[2]);
        c5_reg    <= wide_t'(dr4_reg[0]) + wide_t'(dr4_reg[1]) + wide_t'(dr4_reg[2]);
        hz5_reg   <= wide_t'(sq4_reg[0]) + wide_t'(sq4_reg[2]);
        nh5_reg   <= -(wide_t'(dr4_reg[0]) + wide_t'(dr4_reg[2]));
        gdeg5_reg <= gg4_reg <= (2*CW+2)'(EPS_SQ);
        yg5_reg   <= yg4_reg;
        for (int i = 0; i < 3; i++)
        begin
            d15_reg[i] <= d14_reg[i];
            r5_reg[i]  <= r4_reg[i];
        end
        rq5_reg  <= rq4_reg;
        g5_reg   <= g4_reg;
        rad5_reg <= rad4_reg;
        m5_reg   <= m4_reg;
        rr5_reg  <= rr4_reg;
    end

    // degenerate flags, numerators, context
    always_comb
    begin
        ctx_next        = '0;
        ctx_next.d1x    = d15_reg[0];
        ctx_next.d1y    = d15_reg[1];
        ctx_next.d1z    = d15_reg[2];
        ctx_next.r0     = r5_reg[0];
        ctx_next.r1     = r5_reg[1];
        ctx_next.r2     = r5_reg[2];
        ctx_next.rq     = rq5_reg;
        ctx_next.g      = g5_reg;
        ctx_next.a      = a5_reg;
        ctx_next.negc   = -c5_reg;
        ctx_next.numc   = wide_t'(yg5_reg) - c5_reg;
        ctx_next.m      = m5_reg;
        ctx_next.rad    = rad5_reg;
        ctx_next.rr     = rr5_reg;
        ctx_next.adeg   = a5_reg <= wide_t'(EPS_SQ);
        ctx_next.gdeg   = gdeg5_reg;
        ctx_next.usediv = 1'b0;
        ctx_next.ysel   = Y_ZERO;
        ctx_next.sqfix  = '0;
    end

    always_ff @(posedge clk)
    begin
        num6_reg <= (hz5_reg != '0) ? nh5_reg : '0;
        den6_reg <= hz5_reg;
        ctx6_reg <= ctx_next;
    end

    assign v_out   = v_reg[5];
    assign num_out = num6_reg;
    assign den_out = den6_reg;
    assign ctx_out = ctx6_reg;

endmodule

/* rtl/core/rci_divider.sv */
// pipelined restoring divider: clamp(num/den) to [0,1] in Q1.16, truncated
// one setup stage and one quotient bit per stage; depends on rci_pkg
module rci_divider
    import rci_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  v_in,
    input  wide_t num_in,
    input  wide_t den_in,
    input  ctx_t  ctx_in,
    output logic  v_out,
    output frac_t quot_out,
    output ctx_t  ctx_out
);

    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] den;
        frac_t             q;
        logic              fix;
        frac_t             fixval;
        ctx_t              ctx;
    } div_st_t;

    logic    v_reg  [0:QB];
    div_st_t st_reg [0:QB];
    div_st_t st_next [0:QB];

    // setup: out-of-range numerators give a fixed result
    always_comb
    begin
        st_next[0].rem    = num_in;
        st_next[0].den    = den_in;
        st_next[0].q      = '0;
        st_next[0].fix    = (num_in <= wide_t'(0)) || (num_in >= den_in);
        st_next[0].fixval = (num_in <= wide_t'(0)) ? '0 : frac_t'(ONE_FRAC);
        st_next[0].ctx    = ctx_in;
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [WIDE_W-1:0] t;
        logic              ge;
        always_comb
        begin
            t            = {st_reg[k-1].rem[WIDE_W-2:0], 1'b0};
            ge           = t >= st_reg[k-1].den;
            st_next[k]     = st_reg[k-1];
            st_next[k].rem = ge ? (t - st_reg[k-1].den) : t;
            st_next[k].q   = {st_reg[k-1].q[QB-1:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= v_in;
            for (int k = 1; k <= QB; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QB; k++)
        begin
            st_reg[k] <= st_next[k];
        end
    end

    assign v_out    = v_reg[QB];
    assign quot_out = st_reg[QB].fix ? st_reg[QB].fixval : st_reg[QB].q;
    assign ctx_out  = st_reg[QB].ctx;

endmodule

/* rtl/core/rci_select.sv */
// case selection: checks the unclamped axis parameter and picks the
// numerator for the second division; two stages, depends on rci_pkg
module rci_select
    import rci_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  v_in,
    input  frac_t sq0_in,
    input  ctx_t  ctx_in,
    output logic  v_out,
    output wide_t num_out,
    output wide_t den_out,
    output ctx_t  ctx_out
);

    logic  [1:0] v_reg;
    uw_t   up1_reg;
    frac_t sq01_reg;
    ctx_t  ctx1_reg;
    wide_t num2_reg;
    ctx_t  ctx2_reg;
    uw_t   u_next;
    uw_t   gq_next;
    wide_t num_next;
    ctx_t  ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[0], v_in};
        end
    end

    // d1.y times horizontal fraction
    always_ff @(posedge clk)
    begin
        up1_reg  <= uw_t'(ctx_in.d1y) * uw_t'(signed'({1'b0, sq0_in}));
        sq01_reg <= sq0_in;
        ctx1_reg <= ctx_in;
    end

    // pick case, y offset and numerator
    always_comb
    begin
        u_next   = up1_reg + (uw_t'(ctx1_reg.r1) <<< QB);
        gq_next  = uw_t'(signed'({1'b0, ctx1_reg.g})) <<< QB;
        num_next = '0;
        ctx_next = ctx1_reg;
        ctx_next.usediv = 1'b1;
        ctx_next.sqfix  = '0;
        ctx_next.ysel   = Y_R1;
        if (ctx1_reg.adeg)
        begin
            ctx_next.usediv = 1'b0;
            if (ctx1_reg.gdeg || ctx1_reg.r1 < 0)
                ctx_next.ysel = Y_R1;
            else if (ctx1_reg.rq > 0)
                ctx_next.ysel = Y_RQ;
            else
                ctx_next.ysel = Y_ZERO;
        end
        else if (ctx1_reg.gdeg || u_next < 0)
        begin
            num_next = ctx1_reg.negc;
        end
        else if (u_next > gq_next)
        begin
            num_next      = ctx1_reg.numc;
            ctx_next.ysel = Y_RQ;
        end
        else
        begin
            ctx_next.usediv = 1'b0;
            ctx_next.sqfix  = sq01_reg;
            ctx_next.ysel   = Y_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        num2_reg <= num_next;
        ctx2_reg <= ctx_next;
    end

    assign v_out   = v_reg[1];
    assign num_out = num2_reg;
    assign den_out = ctx2_reg.a;
    assign ctx_out = ctx2_reg;

endmodule

/* rtl/core/rci_back.sv */
// back end: closest-point offsets, squared distance against radius squared,
// result registers; seven stages, depends on rci_pkg
module rci_back
    import rci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             v_in,
    input  frac_t            quot_in,
    input  ctx_t             ctx_in,
    output logic             done,
    output logic             hit,
    output logic [HD_W-1:0]  hit_distance,
    output frac_t            ray_fraction
);

    logic [6:0] v_reg;

    // stage 1
    uw_t             p1_reg [3];
    diff_t           ro1_reg [3];
    logic            yz1_reg;
    logic [HD_W-1:0] hd1_reg;
    frac_t           sq1_reg;
    len_t            rad1_reg;
    rr_t             rr1_reg;
    frac_t           sq_next;
    diff_t           yoff_next;
    logic [QB+RAD_W:0] hp_next;

    // stage 2
    uw_t             dif2_reg [3];
    logic [HD_W-1:0] hd2_reg;
    frac_t           sq2_reg;
    len_t            rad2_reg;
    rr_t             rr2_reg;

    // stage 3
    logic [MG_W-1:0] mg3_reg [3];
    logic            ok3_reg;
    logic [HD_W-1:0] hd3_reg;
    frac_t           sq3_reg;
    rr_t             rr3_reg;
    uw_t             lim_next;
    logic [2:0]      in_next;

    // stage 4
    logic [2*MG_HI-1:0]     hh4_reg [3];
    logic [MG_HI+MG_LO-1:0] hl4_reg [3];
    logic [2*MG_LO-1:0]     ll4_reg [3];
    logic            ok4_reg;
    logic [HD_W-1:0] hd4_reg;
    frac_t           sq4_reg;
    rr_t             rr4_reg;

    // stage 5
    logic [SS_W-1:0] s5_reg [3];
    logic            ok5_reg;
    logic [HD_W-1:0] hd5_reg;
    frac_t           sq5_reg;
    rr_t             rr5_reg;

    // stage 6
    logic [SS_W-1:0] sum6_reg;
    logic            ok6_reg;
    logic [HD_W-1:0] hd6_reg;
    frac_t           sq6_reg;
    rr_t             rr6_reg;

    // result registers
    logic            hit_reg;
    logic [HD_W-1:0] hd_reg;
    frac_t           frac_reg;
    logic            hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:0], v_in};
        end
    end

    // final fraction, offsets along the ray, hit distance product
    always_comb
    begin
        sq_next   = ctx_in.usediv ? quot_in : ctx_in.sqfix;
        yoff_next = (ctx_in.ysel == Y_RQ) ? ctx_in.rq : ctx_in.r1;
        hp_next   = (QB+RAD_W+1)'(sq_next) * (QB+RAD_W+1)'(ctx_in.m);
    end

    always_ff @(posedge clk)
    begin
        p1_reg[0]  <= uw_t'(ctx_in.d1x) * uw_t'(signed'({1'b0, sq_next}));
        p1_reg[1]  <= uw_t'(ctx_in.d1y) * uw_t'(signed'({1'b0, sq_next}));
        p1_reg[2]  <= uw_t'(ctx_in.d1z) * uw_t'(signed'({1'b0, sq_next}));
        ro1_reg[0] <= ctx_in.r0;
        ro1_reg[1] <= yoff_next;
        ro1_reg[2] <= ctx_in.r2;
        yz1_reg    <= ctx_in.ysel == Y_ZERO;
        hd1_reg    <= HD_W'(hp_next >> QB);
        sq1_reg    <= sq_next;
        rad1_reg   <= ctx_in.rad;
        rr1_reg    <= ctx_in.rr;
    end

    // offset vector between the closest points, scaled by the fraction one
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif2_reg[i] <= (i == 1 && yz1_reg) ? '0
                           : (uw_t'(ro1_reg[i]) <<< QB) + p1_reg[i];
        end
        hd2_reg  <= hd1_reg;
        sq2_reg  <= sq1_reg;
        rad2_reg <= rad1_reg;
        rr2_reg  <= rr1_reg;
    end

    // per-axis range check and magnitude
    always_comb
    begin
        lim_next = uw_t'(signed'({1'b0, rad2_reg, QB'(0)}));
        for (int i = 0; i < 3; i++)
        begin
            in_next[i] = (dif2_reg[i] <= lim_next) && (dif2_reg[i] >= -lim_next);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mg3_reg[i] <= dif2_reg[i][UW-1] ? MG_W'(-dif2_reg[i]) : MG_W'(dif2_reg[i]);
        end
        ok3_reg <= &in_next;
        hd3_reg <= hd2_reg;
        sq3_reg <= sq2_reg;
        rr3_reg <= rr2_reg;
    end

    // split squares into partial products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            hh4_reg[i] <= (2*MG_HI)'(mg3_reg[i][MG_W-1:MG_LO])
                          * (2*MG_HI)'(mg3_reg[i][MG_W-1:MG_LO]);
            hl4_reg[i] <= (MG_HI+MG_LO)'(mg3_reg[i][MG_W-1:MG_LO])
                          * (MG_HI+MG_LO)'(mg3_reg[i][MG_LO-1:0]);
            ll4_reg[i] <= (2*MG_LO)'(mg3_reg[i][MG_LO-1:0])
                          * (2*MG_LO)'(mg3_reg[i][MG_LO-1:0]);
        end
        ok4_reg <= ok3_reg;
        hd4_reg <= hd3_reg;
        sq4_reg <= sq3_reg;
        rr4_reg <= rr3_reg;
    end

    // per-axis squares
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_reg[i] <= (SS_W'(hh4_reg[i]) << (2*MG_LO))
                         + (SS_W'(hl4_reg[i]) << (MG_LO+1))
                         + SS_W'(ll4_reg[i]);
        end
        ok5_reg <= ok4_reg;
        hd5_reg <= hd4_reg;
        sq5_reg <= sq4_reg;
        rr5_reg <= rr4_reg;
    end

    // squared distance
    always_ff @(posedge clk)
    begin
        sum6_reg <= s5_reg[0] + s5_reg[1] + s5_reg[2];
        ok6_reg  <= ok5_reg;
        hd6_reg  <= hd5_reg;
        sq6_reg  <= sq5_reg;
        rr6_reg  <= rr5_reg;
    end

    // compare against radius squared
    assign hit_next = ok6_reg && !(sum6_reg > (SS_W'(rr6_reg) << (2*QB)));

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        hd_reg   <= hit_next ? hd6_reg : '0;
        frac_reg <= sq6_reg;
    end

    assign done         = v_reg[6];
    assign hit          = hit_reg;
    assign hit_distance = hd_reg;
    assign ray_fraction = frac_reg;

endmodule
